// ===== design/span_clip_draw_engine_defines.svh =====
// Assertion macros for the span clip draw engine.
// Used by the top level only; no other dependencies.
`ifndef SPAN_CLIP_DRAW_ENGINE_DEFINES_SVH
`define SPAN_CLIP_DRAW_ENGINE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SPCD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("span clip draw engine: check failed");

// Antecedent implies consequent in the next cycle.
`define SPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("span clip draw engine: check failed");

`endif

// ===== design/spcd_pkg.sv =====
// Shared types and constants for the span clip draw engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package spcd_pkg;

    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_COORD_BITS = 16;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = 17;
    localparam int SUM_W   = 18;
    localparam int OUT_W   = 13;
    localparam int HGT_W   = 7;
    localparam int ORG_W   = 12;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [OUT_W-1:0] RST_CLIP_WIDTH  = 13'd4096;
    localparam logic [HGT_W-1:0] RST_CLIP_HEIGHT = 7'd64;
    localparam logic [ORG_W-1:0] RST_ORIGIN_X    = 12'd0;
    localparam logic [ORG_W-1:0] RST_ORIGIN_Y    = 12'd0;

    typedef enum logic [1:0] {
        REG_CLIP_WIDTH  = 2'd0,
        REG_CLIP_HEIGHT = 2'd1,
        REG_ORIGIN_X    = 2'd2,
        REG_ORIGIN_Y    = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FUNC_HLINE = 2'd0,
        FUNC_VLINE = 2'd1,
        FUNC_RECT  = 2'd2,
        FUNC_BOX   = 2'd3
    } func_t;

    localparam logic [1:0] RECT_LAST_STEP = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN   = 2'd1,
        ST_FLUSH = 2'd2
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic hold_load;
        logic out_load;
        logic out_last;
    } ctl_cmd_t;

    typedef struct packed {
        logic cand_vis;
        logic last_step;
        logic no_steps;
    } dp_status_t;

endpackage

// ===== design/span_clip_draw_engine.sv =====
// Top level of the span clip draw engine: register port, controller and datapath.
// Depends on spcd_pkg, spcd_ctrl, spcd_datapath and span_clip_draw_engine_defines.svh.
`timescale 1ns / 1ps

// Takes one drawing command per input transaction (horizontal line, vertical line,
// rectangle outline or filled box), clips each line to the window and sends each
// visible span, origin added, as one output transaction; the final span of a command
// carries last, and a command with no visible span produces no output. Commands are
// handled one at a time, in one step per line tried (1 for a line, 4 for a rectangle,
// one per window row covered for a box, so at most 64 with MAX_ROWS of 64; just 1 when
// the window is empty or a box covers no row); the span stepper produces one candidate
// span per cycle and stalls only when the output register is still occupied. The
// next command is accepted while the last span waits in the output register.
// Registers (APB, 4-byte stride): clip_width, clip_height, origin_x, origin_y;
// write them only while idle.

`include "span_clip_draw_engine_defines.svh"

module span_clip_draw_engine
    import spcd_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_W-1:0]     paddr,
    input  logic [CFG_DATA_W-1:0]     pwdata,
    output logic [CFG_DATA_W-1:0]     prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                func,
    input  logic signed [COORD_W-1:0] x_a,
    input  logic signed [COORD_W-1:0] y_a,
    input  logic signed [COORD_W-1:0] x_b,
    input  logic signed [COORD_W-1:0] y_b,
    input  logic signed [COORD_W-1:0] span_len,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      vertical,
    output logic [OUT_W-1:0]          out_x,
    output logic [OUT_W-1:0]          out_y,
    output logic signed [OUT_W-1:0]   out_len,
    output logic                      last
);

    logic [OUT_W-1:0] clip_width_reg;
    logic [HGT_W-1:0] clip_height_reg;
    logic [ORG_W-1:0] origin_x_reg, origin_y_reg;
    logic             cfg_wr;
    cfg_reg_t         cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_width_reg  <= RST_CLIP_WIDTH;
            clip_height_reg <= RST_CLIP_HEIGHT;
            origin_x_reg    <= RST_ORIGIN_X;
            origin_y_reg    <= RST_ORIGIN_Y;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_CLIP_WIDTH:  clip_width_reg  <= pwdata[OUT_W-1:0];
                REG_CLIP_HEIGHT: clip_height_reg <= pwdata[HGT_W-1:0];
                REG_ORIGIN_X:    origin_x_reg    <= pwdata[ORG_W-1:0];
                default:         origin_y_reg    <= pwdata[ORG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_CLIP_WIDTH:  prdata = CFG_DATA_W'(clip_width_reg);
            REG_CLIP_HEIGHT: prdata = CFG_DATA_W'(clip_height_reg);
            REG_ORIGIN_X:    prdata = CFG_DATA_W'(origin_x_reg);
            default:         prdata = CFG_DATA_W'(origin_y_reg);
        endcase
    end

    ctl_cmd_t   cmd;
    dp_status_t st;

    spcd_ctrl #(
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    spcd_datapath #(
        .MAX_ROWS   (MAX_ROWS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .st          (st),
        .clip_width  (clip_width_reg),
        .clip_height (clip_height_reg),
        .origin_x    (origin_x_reg),
        .origin_y    (origin_y_reg),
        .func        (func),
        .x_a         (x_a),
        .y_a         (y_a),
        .x_b         (x_b),
        .y_b         (y_b),
        .span_len    (span_len),
        .vertical    (vertical),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_len     (out_len),
        .last        (last)
    );

    // a pending output transaction is never overwritten
    `SPCD_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid || out_ready)
    // the stepper never runs past the final line of a command
    `SPCD_ASSERT_SAME(a_step_bounded, clk, rst_n, cmd.step, !st.last_step && !st.no_steps)
    // an accepted command keeps the input closed on the next cycle
    `SPCD_ASSERT_NEXT(a_busy_after_load, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

// ===== design/spcd_ctrl.sv =====
// Sequencing controller: command acceptance, span stepping, hold and output valids.
// Depends on spcd_pkg.
`timescale 1ns / 1ps

module spcd_ctrl
    import spcd_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t st,
    output ctl_cmd_t   cmd
);

    localparam int CNT_W = $clog2(MAX_ROWS + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             hold_valid_reg, hold_valid_next;
    logic             out_valid_reg, out_valid_next;

    logic out_busy;
    logic take;
    logic stall;
    logic final_step;

    assign out_busy   = out_valid_reg && !out_ready;
    assign take       = st.cand_vis && !st.no_steps && (cnt_reg < CNT_W'(MAX_ROWS));
    assign stall      = take && hold_valid_reg && out_busy;
    assign final_step = st.last_step || st.no_steps;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (!stall && final_step)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (!(hold_valid_reg && out_busy))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RUN:
            begin
                if (!stall)
                begin
                    cmd.hold_load = take;
                    cmd.out_load  = take && hold_valid_reg;
                    cmd.step      = !final_step;
                end
            end
            ST_FLUSH:
            begin
                if (hold_valid_reg && !out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        hold_valid_next = hold_valid_reg;
        if (cmd.load)
            cnt_next = '0;
        else if (cmd.hold_load)
            cnt_next = cnt_reg + 1'b1;

        if (cmd.hold_load)
            hold_valid_next = 1'b1;
        else if (cmd.out_load && cmd.out_last)
            hold_valid_next = 1'b0;

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/spcd_datapath.sv =====
// Datapath: held command, row and step counters, span clipper, hold and output registers.
// Depends on spcd_pkg.
`timescale 1ns / 1ps

module spcd_datapath
    import spcd_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                      clk,
    input  ctl_cmd_t                  cmd,
    output dp_status_t                st,
    input  logic [OUT_W-1:0]          clip_width,
    input  logic [HGT_W-1:0]          clip_height,
    input  logic [ORG_W-1:0]          origin_x,
    input  logic [ORG_W-1:0]          origin_y,
    input  logic [1:0]                func,
    input  logic signed [COORD_W-1:0] x_a,
    input  logic signed [COORD_W-1:0] y_a,
    input  logic signed [COORD_W-1:0] x_b,
    input  logic signed [COORD_W-1:0] y_b,
    input  logic signed [COORD_W-1:0] span_len,
    output logic                      vertical,
    output logic [OUT_W-1:0]          out_x,
    output logic [OUT_W-1:0]          out_y,
    output logic signed [OUT_W-1:0]   out_len,
    output logic                      last
);

    localparam int SH    = COORD_W - COORD_BITS;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    function automatic logic signed [COORD_W-1:0] sx(input logic [COORD_W-1:0] v);
        logic signed [COORD_W-1:0] t;
        t  = v << SH;
        sx = t >>> SH;
    endfunction

    // window size
    logic [HGT_W-1:0] win_h;
    assign win_h = (clip_height > HGT_W'(MAX_ROWS)) ? HGT_W'(MAX_ROWS) : clip_height;

    // held command
    func_t                     func_reg;
    logic signed [COORD_W-1:0] xa_reg, ya_reg, xb_reg, yb_reg, len_reg;
    logic signed [DIFF_W-1:0]  dx_reg, ndx_reg, dy_reg, ndy_reg;
    logic [1:0]                step_reg;
    logic [ROW_W-1:0]          row_reg, stop_reg;
    logic                      up_reg, box_empty_reg;

    // load-time box row setup
    logic signed [COORD_W-1:0] xa_s, ya_s, xb_s, yb_s;
    logic signed [DIFF_W-1:0]  ya_w, yb_w, h1, y0, ystop;
    logic                      up, box_empty;

    assign xa_s = sx(x_a);
    assign ya_s = sx(y_a);
    assign xb_s = sx(x_b);
    assign yb_s = sx(y_b);
    assign ya_w = DIFF_W'(ya_s);
    assign yb_w = DIFF_W'(yb_s);
    assign h1   = $signed({{(DIFF_W-HGT_W){1'b0}}, win_h}) - DIFF_W'(1);
    assign up   = (yb_w >= ya_w);

    always_comb
    begin
        if (up)
        begin
            y0        = (ya_w < 0) ? '0 : ya_w;
            ystop     = (yb_w > h1) ? h1 : yb_w;
            box_empty = (y0 > ystop);
        end
        else
        begin
            y0        = (ya_w > h1) ? h1 : ya_w;
            ystop     = (yb_w < 0) ? '0 : yb_w;
            box_empty = (y0 < ystop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg      <= func_t'(func);
            xa_reg        <= xa_s;
            ya_reg        <= ya_s;
            xb_reg        <= xb_s;
            yb_reg        <= yb_s;
            len_reg       <= sx(span_len);
            dx_reg        <= DIFF_W'(xb_s) - DIFF_W'(xa_s);
            ndx_reg       <= DIFF_W'(xa_s) - DIFF_W'(xb_s);
            dy_reg        <= DIFF_W'(yb_s) - DIFF_W'(ya_s);
            ndy_reg       <= DIFF_W'(ya_s) - DIFF_W'(yb_s);
            step_reg      <= '0;
            row_reg       <= y0[ROW_W-1:0];
            stop_reg      <= ystop[ROW_W-1:0];
            up_reg        <= up;
            box_empty_reg <= box_empty;
        end
        else if (cmd.step)
        begin
            step_reg <= step_reg + 1'b1;
            row_reg  <= up_reg ? row_reg + 1'b1 : row_reg - 1'b1;
        end
    end

    // candidate span select
    logic                      c_vert;
    logic signed [COORD_W-1:0] c_along;
    logic signed [DIFF_W-1:0]  c_across;
    logic signed [DIFF_W-1:0]  c_len;

    always_comb
    begin
        c_vert   = 1'b0;
        c_along  = xa_reg;
        c_across = DIFF_W'(ya_reg);
        c_len    = DIFF_W'(len_reg);
        unique case (func_reg)
            FUNC_HLINE: ;
            FUNC_VLINE:
            begin
                c_vert   = 1'b1;
                c_along  = ya_reg;
                c_across = DIFF_W'(xa_reg);
            end
            FUNC_RECT:
            begin
                unique case (step_reg)
                    2'd0:
                    begin
                        c_len = dx_reg;
                    end
                    2'd1:
                    begin
                        c_vert   = 1'b1;
                        c_along  = ya_reg;
                        c_across = DIFF_W'(xb_reg);
                        c_len    = dy_reg;
                    end
                    2'd2:
                    begin
                        c_along  = xb_reg;
                        c_across = DIFF_W'(yb_reg);
                        c_len    = ndx_reg;
                    end
                    default:
                    begin
                        c_vert   = 1'b1;
                        c_along  = yb_reg;
                        c_across = DIFF_W'(xa_reg);
                        c_len    = ndy_reg;
                    end
                endcase
            end
            default:
            begin
                c_across = $signed({{(DIFF_W-ROW_W){1'b0}}, row_reg});
                c_len    = dx_reg;
            end
        endcase
    end

    // clip against the window
    logic [OUT_W-1:0]        lim, alim, a_c, e_c;
    logic signed [SUM_W-1:0] along_w, across_w, len_w, e_w, lim_s, alim_s;
    logic signed [OUT_W:0]   d_len;

    assign lim      = c_vert ? OUT_W'(win_h) : clip_width;
    assign alim     = c_vert ? clip_width : OUT_W'(win_h);
    assign along_w  = SUM_W'(c_along);
    assign across_w = SUM_W'(c_across);
    assign len_w    = SUM_W'(c_len);
    assign e_w      = along_w + len_w;
    assign lim_s    = $signed({{(SUM_W-OUT_W){1'b0}}, lim});
    assign alim_s   = $signed({{(SUM_W-OUT_W){1'b0}}, alim});

    always_comb
    begin
        if (along_w < 0)
            a_c = '0;
        else if (along_w >= lim_s)
            a_c = lim - 1'b1;
        else
            a_c = along_w[OUT_W-1:0];

        if (e_w < 0)
            e_c = '0;
        else if (e_w >= lim_s)
            e_c = lim - 1'b1;
        else
            e_c = e_w[OUT_W-1:0];
    end

    assign d_len = $signed({1'b0, e_c}) - $signed({1'b0, a_c});

    logic last_step_c;

    assign st.cand_vis  = (across_w >= 0) && (across_w < alim_s)
                          && !(along_w < 0 && e_w < 0)
                          && !(along_w >= lim_s && e_w >= lim_s);
    assign st.no_steps  = (clip_width == '0) || (win_h == '0)
                          || (func_reg == FUNC_BOX && box_empty_reg);
    assign st.last_step = last_step_c;

    always_comb
    begin
        unique case (func_reg)
            FUNC_HLINE,
            FUNC_VLINE: last_step_c = 1'b1;
            FUNC_RECT:  last_step_c = (step_reg == RECT_LAST_STEP);
            default:    last_step_c = (row_reg == stop_reg);
        endcase
    end

    // hold one span back so the final one can carry the last mark
    logic                    hold_vert_reg;
    logic [OUT_W-1:0]        hold_x_reg, hold_y_reg;
    logic signed [OUT_W-1:0] hold_len_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.hold_load)
        begin
            hold_vert_reg <= c_vert;
            hold_x_reg    <= c_vert ? across_w[OUT_W-1:0] : a_c;
            hold_y_reg    <= c_vert ? a_c : across_w[OUT_W-1:0];
            hold_len_reg  <= d_len[OUT_W-1:0];
        end
    end

    logic                    vert_reg, last_reg;
    logic [OUT_W-1:0]        x_reg, y_reg;
    logic signed [OUT_W-1:0] len_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            vert_reg    <= hold_vert_reg;
            x_reg       <= hold_x_reg + OUT_W'(origin_x);
            y_reg       <= hold_y_reg + OUT_W'(origin_y);
            len_out_reg <= hold_len_reg;
            last_reg    <= cmd.out_last;
        end
    end

    assign vertical = vert_reg;
    assign out_x    = x_reg;
    assign out_y    = y_reg;
    assign out_len  = len_out_reg;
    assign last     = last_reg;

endmodule

// ===== verif/span_clip_tb_pkg.sv =====
// Span predictor and scoreboard for the span clip draw engine testbench.
// Depends on spcd_pkg for the command codes, register indexes, widths and reset values.
`timescale 1ns / 1ps

package span_clip_tb_pkg;
    import spcd_pkg::*;

    typedef struct {
        bit             vert;
        bit [OUT_W-1:0] x;
        bit [OUT_W-1:0] y;
        bit [OUT_W-1:0] len;
        bit             last;
    } span_t;

    typedef struct {
        func_t                     f;
        logic signed [COORD_W-1:0] xa;
        logic signed [COORD_W-1:0] ya;
        logic signed [COORD_W-1:0] xb;
        logic signed [COORD_W-1:0] yb;
        logic signed [COORD_W-1:0] len;
    } draw_cmd_t;

    class span_clip_scoreboard;
        bit [OUT_W-1:0] clip_w;
        bit [HGT_W-1:0] clip_h;
        bit [ORG_W-1:0] org_x;
        bit [ORG_W-1:0] org_y;
        span_t          cmd_spans[$];
        span_t          pending_spans[$];
        int             errors;
        int             spans_checked;
        int             commands_seen;

        function new();
            clip_w = RST_CLIP_WIDTH;
            clip_h = RST_CLIP_HEIGHT;
            org_x  = RST_ORIGIN_X;
            org_y  = RST_ORIGIN_Y;
        endfunction

        function void set_reg(cfg_reg_t r, logic [31:0] v);
            case (r)
                REG_CLIP_WIDTH:  clip_w = v[OUT_W-1:0];
                REG_CLIP_HEIGHT: clip_h = v[HGT_W-1:0];
                REG_ORIGIN_X:    org_x  = v[ORG_W-1:0];
                default:         org_y  = v[ORG_W-1:0];
            endcase
        endfunction

        function int pending();
            return pending_spans.size();
        endfunction

        function void add_span(bit vert, longint px, longint py, longint plen);
            span_t  s;
            longint sx;
            longint sy;
            if (cmd_spans.size() >= DEF_MAX_ROWS)
                return;
            sx     = px + longint'(org_x);
            sy     = py + longint'(org_y);
            s.vert = vert;
            s.x    = sx[OUT_W-1:0];
            s.y    = sy[OUT_W-1:0];
            s.len  = plen[OUT_W-1:0];
            s.last = 1'b0;
            cmd_spans.push_back(s);
        endfunction

        // along runs the length of the span, across is checked against alim
        function void clip_span(bit vert, longint along, longint across, longint len,
                                longint lim, longint alim);
            longint e;
            e = along + len;
            if (across < 0 || across >= alim)
                return;
            if (along < 0)
            begin
                if (e < 0)
                    return;
                along = 0;
            end
            if (along >= lim)
            begin
                if (e >= lim)
                    return;
                along = lim - 1;
            end
            if (e < 0)
                e = 0;
            if (e >= lim)
                e = lim - 1;
            if (vert)
                add_span(1'b1, across, along, e - along);
            else
                add_span(1'b0, along, across, e - along);
        endfunction

        function void note_command(func_t f, logic signed [COORD_W-1:0] sxa,
                                   logic signed [COORD_W-1:0] sya,
                                   logic signed [COORD_W-1:0] sxb,
                                   logic signed [COORD_W-1:0] syb,
                                   logic signed [COORD_W-1:0] slen);
            longint xa;
            longint ya;
            longint xb;
            longint yb;
            longint len;
            longint win_w;
            longint win_h;
            longint w;
            longint row;
            longint stop;
            xa  = longint'(sxa);
            ya  = longint'(sya);
            xb  = longint'(sxb);
            yb  = longint'(syb);
            len = longint'(slen);
            commands_seen++;
            cmd_spans.delete();
            win_w = longint'(clip_w);
            win_h = (clip_h > DEF_MAX_ROWS) ? DEF_MAX_ROWS : longint'(clip_h);
            if (win_w == 0 || win_h == 0)
                return;
            case (f)
                FUNC_HLINE: clip_span(1'b0, xa, ya, len, win_w, win_h);
                FUNC_VLINE: clip_span(1'b1, ya, xa, len, win_h, win_w);
                FUNC_RECT:
                begin
                    clip_span(1'b0, xa, ya, xb - xa, win_w, win_h);
                    clip_span(1'b1, ya, xb, yb - ya, win_h, win_w);
                    clip_span(1'b0, xb, yb, xa - xb, win_w, win_h);
                    clip_span(1'b1, yb, xa, ya - yb, win_h, win_w);
                end
                default:
                begin
                    w = xb - xa;
                    if (yb >= ya)
                    begin
                        row  = (ya < 0) ? 0 : ya;
                        stop = (yb > win_h - 1) ? win_h - 1 : yb;
                        while (row <= stop)
                        begin
                            clip_span(1'b0, xa, row, w, win_w, win_h);
                            row++;
                        end
                    end
                    else
                    begin
                        row  = (ya > win_h - 1) ? win_h - 1 : ya;
                        stop = (yb < 0) ? 0 : yb;
                        while (row >= stop)
                        begin
                            clip_span(1'b0, xa, row, w, win_w, win_h);
                            row--;
                        end
                    end
                end
            endcase
            if (cmd_spans.size() > 0)
                cmd_spans[cmd_spans.size() - 1].last = 1'b1;
            foreach (cmd_spans[i])
                pending_spans.push_back(cmd_spans[i]);
        endfunction

        function void check_span(logic vert, logic [OUT_W-1:0] x, logic [OUT_W-1:0] y,
                                 logic [OUT_W-1:0] len, logic lst);
            span_t e;
            spans_checked++;
            if (pending_spans.size() == 0)
            begin
                $error("span with nothing pending: vertical %0b x %0d y %0d len %0d last %0b",
                       vert, x, y, $signed(len), lst);
                errors++;
                return;
            end
            e = pending_spans.pop_front();
            if (vert !== e.vert)
            begin
                $error("vertical: expected %0b, got %0b", e.vert, vert);
                errors++;
            end
            if (x !== e.x)
            begin
                $error("out_x: expected %0d, got %0d", e.x, x);
                errors++;
            end
            if (y !== e.y)
            begin
                $error("out_y: expected %0d, got %0d", e.y, y);
                errors++;
            end
            if (len !== e.len)
            begin
                $error("out_len: expected %0d, got %0d", $signed(e.len), $signed(len));
                errors++;
            end
            if (lst !== e.last)
            begin
                $error("last: expected %0b, got %0b", e.last, lst);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== verif/testbench.sv =====
// Top-level testbench for span_clip_draw_engine: clock, reset, APB register writes,
// command and span handshake drivers. Depends on spcd_pkg and span_clip_tb_pkg.
`timescale 1ns / 1ps

module testbench;
    import spcd_pkg::*;
    import span_clip_tb_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 100;
    localparam int LONG_HOLD    = 300;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [CFG_ADDR_W-1:0]     paddr;
    logic [CFG_DATA_W-1:0]     pwdata;
    logic [CFG_DATA_W-1:0]     prdata;
    logic                      pready;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                func;
    logic signed [COORD_W-1:0] x_a;
    logic signed [COORD_W-1:0] y_a;
    logic signed [COORD_W-1:0] x_b;
    logic signed [COORD_W-1:0] y_b;
    logic signed [COORD_W-1:0] span_len;
    logic                      out_valid;
    logic                      out_ready;
    logic                      vertical;
    logic [OUT_W-1:0]          out_x;
    logic [OUT_W-1:0]          out_y;
    logic signed [OUT_W-1:0]   out_len;
    logic                      last;

    span_clip_scoreboard sb;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    bit                  long_hold_req;
    bit                  long_hold_done;
    int unsigned         cycles = 0;
    int                  settings_run = 1;

    span_clip_draw_engine DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    initial
    begin
        wait (cycles >= LIMIT_CYCLES);
        $display("Mismatches found");
        $finish;
    end

    // spans are checked before the command accepted at the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_span(vertical, out_x, out_y, out_len, last);
            if (in_valid && in_ready)
                sb.note_command(func_t'(func), x_a, y_a, x_b, y_b, span_len);
        end
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic draw_cmd_t cmd_of(func_t f, int xa, int ya, int xb, int yb, int len);
        draw_cmd_t c;
        c.f   = f;
        c.xa  = xa[COORD_W-1:0];
        c.ya  = ya[COORD_W-1:0];
        c.xb  = xb[COORD_W-1:0];
        c.yb  = yb[COORD_W-1:0];
        c.len = len[COORD_W-1:0];
        return c;
    endfunction

    // mostly near the window, sometimes anywhere or at the extremes
    function automatic int rand_coord(int lim);
        int v;
        case ($urandom_range(9))
            0: v = int'($urandom);
            1:
            begin
                case ($urandom_range(3))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = -1;
                    default: v = 0;
                endcase
            end
            default: v = int'($urandom_range(lim + 16)) - 8;
        endcase
        return v;
    endfunction

    function automatic int rand_len(int lim);
        if ($urandom_range(9) == 0)
            return int'($urandom);
        return int'($urandom_range(2 * lim + 16)) - lim - 8;
    endfunction

    function automatic draw_cmd_t rand_cmd();
        int w;
        int h;
        w = (sb.clip_w == 0) ? 16 : int'(sb.clip_w);
        h = (sb.clip_h == 0) ? 16 : int'(sb.clip_h);
        return cmd_of(func_t'($urandom_range(3)), rand_coord(w), rand_coord(h),
                      rand_coord(w), rand_coord(h), rand_len($urandom_range(1) ? w : h));
    endfunction

    task automatic write_reg(cfg_reg_t r, logic [31:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(r, v);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_cmd(draw_cmd_t c);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= c.f;
        x_a      <= c.xa;
        y_a      <= c.ya;
        x_b      <= c.xb;
        y_b      <= c.yb;
        span_len <= c.len;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // empty boxes give no spans but still keep the block busy for a while
    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int w, int h, int ox, int oy, int s_pct, int r_pct, int n,
                             bit hold);
        write_reg(REG_CLIP_WIDTH, w);
        write_reg(REG_CLIP_HEIGHT, h);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        long_hold_req  = hold;
        for (int k = 0; k < n; k++)
            send_cmd(rand_cmd());
        stop_sending();
        drain();
        long_hold_req = 1'b0;
        settings_run++;
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        func           = FUNC_HLINE;
        x_a            = '0;
        y_a            = '0;
        x_b            = '0;
        y_b            = '0;
        span_len       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_req  = 1'b0;
        long_hold_done = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed commands against the reset window
        send_cmd(cmd_of(FUNC_HLINE, 10, 5, 1234, -77, 100));
        send_cmd(cmd_of(FUNC_HLINE, 100, 5, 0, 0, -50));
        send_cmd(cmd_of(FUNC_HLINE, -10, 3, 0, 0, 20));
        send_cmd(cmd_of(FUNC_HLINE, -10, 3, 0, 0, 5));
        send_cmd(cmd_of(FUNC_HLINE, 5000, 3, 0, 0, -2000));
        send_cmd(cmd_of(FUNC_HLINE, 4096, 0, 0, 0, 10));
        send_cmd(cmd_of(FUNC_HLINE, 0, -1, 0, 0, 10));
        send_cmd(cmd_of(FUNC_HLINE, 0, 64, 0, 0, 10));
        send_cmd(cmd_of(FUNC_HLINE, -32768, 0, 0, 0, 32767));
        send_cmd(cmd_of(FUNC_HLINE, 32767, 63, -1, -1, -32768));
        send_cmd(cmd_of(FUNC_VLINE, 7, 10, 0, 0, 20));
        send_cmd(cmd_of(FUNC_VLINE, 7, -5, 0, 0, 100));
        send_cmd(cmd_of(FUNC_VLINE, 4096, 10, 0, 0, 5));
        send_cmd(cmd_of(FUNC_VLINE, -32768, -32768, 32767, 32767, -1));
        send_cmd(cmd_of(FUNC_VLINE, 0, 63, 0, 0, -32768));
        send_cmd(cmd_of(FUNC_RECT, 1, 1, 20, 10, 0));
        send_cmd(cmd_of(FUNC_RECT, -5, -5, 5000, 100, 32767));
        send_cmd(cmd_of(FUNC_RECT, -32768, -32768, 32767, 32767, -32768));
        send_cmd(cmd_of(FUNC_BOX, 0, 0, 15, 3, 0));
        send_cmd(cmd_of(FUNC_BOX, 10, 62, 30, 50, -1));
        send_cmd(cmd_of(FUNC_BOX, -32768, -32768, 32767, 32767, 0));
        send_cmd(cmd_of(FUNC_BOX, 0, 100, 10, 200, 0));
        send_cmd(cmd_of(FUNC_BOX, 0, 100, 10, 70, 0));
        send_cmd(cmd_of(FUNC_BOX, 0, 0, 0, 0, 0));
        stop_sending();
        drain();

        run_phase(4096, 64, 0, 0, 0, 0, 50, 1'b0);
        run_phase(1, 1, 4095, 4095, 82, 0, 30, 1'b0);
        run_phase(8191, 127, 4095, 4095, 0, 82, 40, 1'b0);
        run_phase($urandom_range(1, 64), $urandom_range(1, 16), $urandom_range(4095),
                  $urandom_range(4095), 20, 20, 50, 1'b0);
        run_phase(0, 64, $urandom_range(4095), $urandom_range(4095), 0, 0, 15, 1'b0);
        run_phase(300, 0, $urandom_range(4095), $urandom_range(4095), 20, 20, 15, 1'b0);
        run_phase($urandom_range(1, 4096), 64, $urandom_range(4095), $urandom_range(4095),
                  0, 0, 60, 1'b1);
        run_phase($urandom_range(1, 200), $urandom_range(1, 64), $urandom_range(4095),
                  $urandom_range(4095), 82, 0, 50, 1'b0);
        run_phase($urandom_range(1, 4096), $urandom_range(1, 127), $urandom_range(4095),
                  $urandom_range(4095), 0, 82, 50, 1'b0);
        run_phase($urandom_range(1, 8191), $urandom_range(1, 64), $urandom_range(4095),
                  $urandom_range(4095), 20, 20, 60, 1'b0);

        $display("Ran %0d draw commands under %0d window settings, %0d spans compared,",
                 sb.commands_seen, settings_run, sb.spans_checked);
        $display("with empty and over-tall windows, idle gaps and one long output stall.");
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
